### hdl/ftc_pkg.sv
`timescale 1ns / 1ps

package ftc_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 1024;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CFG_ENGLISH_PCT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CODE_PCT = 1'b1;
  localparam logic [CfgDataW-1:0] ENGLISH_PCT_RESET = 7'd25;
  localparam logic [CfgDataW-1:0] CODE_PCT_RESET = 7'd1;

  typedef enum logic [1:0] {
    KIND_REGULAR = 2'd0,
    KIND_DIR = 2'd1,
    KIND_CHARDEV = 2'd2,
    KIND_BLOCKDEV = 2'd3
  } file_kind_e;

  typedef enum logic [3:0] {
    CLS_DIR = 4'd0,
    CLS_CHARDEV = 4'd1,
    CLS_BLOCKDEV = 4'd2,
    CLS_EMPTY = 4'd3,
    CLS_MAGIC = 4'd4,
    CLS_SCRIPT = 4'd5,
    CLS_C_PROG = 4'd6,
    CLS_ENGLISH = 4'd7,
    CLS_ASCII = 4'd8,
    CLS_DATA = 4'd9
  } file_class_e;

  typedef enum logic [1:0] {
    STRIP_NONE = 2'd0,
    STRIP_STRIPPED = 2'd1,
    STRIP_NOT_STRIPPED = 2'd2
  } strip_e;

  // which symbol word decides stripped / not stripped
  typedef enum logic [1:0] {
    EXE_NONE = 2'd0,
    EXE_WORD_B = 2'd1,
    EXE_WORD_A = 2'd2
  } sig_exe_e;

  // head bytes little endian: byte i at bits 8i+7..8i
  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] value;
    sig_exe_e exe;
  } sig_t;

  localparam int unsigned SIG_COUNT = 19;
  localparam int unsigned SigIdxW = 5;

  localparam logic [31:0] M2 = 32'h0000_ffff;
  localparam logic [31:0] M3 = 32'h00ff_ffff;
  localparam logic [31:0] M4 = 32'hffff_ffff;

  localparam sig_t SIG_TABLE [SIG_COUNT] = '{
    '{M3, 32'h008d_9d1f, EXE_NONE},
    '{M3, 32'h0090_9d1f, EXE_NONE},
    '{M2, 32'h0000_ff65, EXE_NONE},
    '{M2, 32'h0000_ff2c, EXE_NONE},
    '{M2, 32'h0000_ff65, EXE_NONE},
    '{M4, 32'h2075_6e47, EXE_NONE},
    '{M4, 32'h7261_3c21, EXE_NONE},
    '{M2, 32'h0000_0201, EXE_NONE},
    '{M2, 32'h0000_86a3, EXE_NONE},
    '{M4, 32'h0701_0000, EXE_NONE},
    '{M4, 32'h0000_0107, EXE_NONE},
    '{M4, 32'h0410_0301, EXE_WORD_B},
    '{M4, 32'h0420_0301, EXE_WORD_B},
    '{M4, 32'h1020_0301, EXE_WORD_B},
    '{M4, 32'h1010_0301, EXE_WORD_B},
    '{M4, 32'h0103_1004, EXE_WORD_B},
    '{M4, 32'h0b10_0301, EXE_WORD_B},
    '{M4, 32'h0000_010b, EXE_WORD_A},
    '{M4, 32'h010b_0000, EXE_WORD_A}
  };

  // per-file summary handed from the accumulator to the verdict logic
  typedef struct packed {
    file_kind_e kind;
    logic exec_any;
    logic nonascii;
    logic sym_a_nz;
    logic sym_b_nz;
    logic [31:0] head;
  } snap_t;

endpackage

### hdl/ftc_accum.sv
`timescale 1ns / 1ps

module ftc_accum #(
  parameter int unsigned BlockBytes = ftc_pkg::BLOCK_BYTES_DEF,
  localparam int unsigned CntW = $clog2(BlockBytes + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic item_valid_i,
  output logic item_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic byte_present_i,
  input  logic last_item_i,
  input  logic [1:0] file_kind_i,
  input  logic exec_any_i,
  output logic snap_valid_o,
  input  logic snap_ready_i,
  output ftc_pkg::snap_t snap_o,
  output logic [CntW-1:0] snap_count_o,
  output logic [CntW-1:0] snap_punct_o,
  output logic [CntW-1:0] snap_letter_o
);

  logic [CntW-1:0] cnt_q, cnt_d, punct_q, punct_d, letter_q, letter_d;
  logic nonascii_q, nonascii_d, sym_a_q, sym_a_d, sym_b_q, sym_b_d;
  logic [31:0] head_q, head_d;
  logic snap_valid_q;
  ftc_pkg::snap_t snap_q;
  logic [CntW-1:0] snap_cnt_q, snap_punct_q, snap_letter_q;
  logic fire;

  always_comb begin
    logic [7:0] lc;
    logic take;
    cnt_d = cnt_q;
    punct_d = punct_q;
    letter_d = letter_q;
    nonascii_d = nonascii_q;
    sym_a_d = sym_a_q;
    sym_b_d = sym_b_q;
    head_d = head_q;
    lc = data_byte_i;
    if (data_byte_i inside {[8'h41:8'h5a]}) begin
      lc = data_byte_i | 8'h20;
    end
    take = byte_present_i && (cnt_q < CntW'(BlockBytes));
    if (take) begin
      if (cnt_q < CntW'(4)) begin
        head_d[{cnt_q[1:0], 3'b000} +: 8] = data_byte_i;
      end
      if (data_byte_i != 8'h00 && cnt_q >= CntW'(16) && cnt_q <= CntW'(19)) begin
        sym_a_d = 1'b1;
      end
      if (data_byte_i != 8'h00 && cnt_q >= CntW'(28) && cnt_q <= CntW'(31)) begin
        sym_b_d = 1'b1;
      end
      if (data_byte_i[7]) begin
        nonascii_d = 1'b1;
      end
      if (data_byte_i inside {8'h3b, 8'h7b, 8'h7d, 8'h23, 8'h2a, 8'h3c, 8'h3e, 8'h2f}) begin
        punct_d = punct_q + CntW'(1);
      end
      if (lc inside {8'h65, 8'h74, 8'h61, 8'h6f, 8'h69, 8'h6e, 8'h73}) begin
        letter_d = letter_q + CntW'(1);
      end
      cnt_d = cnt_q + CntW'(1);
    end
  end

  // a non-closing transaction never waits; the closing one needs a free snapshot slot
  assign item_ready_o = !last_item_i || !snap_valid_q || snap_ready_i;
  assign fire = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      punct_q <= '0;
      letter_q <= '0;
      nonascii_q <= 1'b0;
      sym_a_q <= 1'b0;
      sym_b_q <= 1'b0;
      head_q <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (fire && last_item_i) begin
        cnt_q <= '0;
        punct_q <= '0;
        letter_q <= '0;
        nonascii_q <= 1'b0;
        sym_a_q <= 1'b0;
        sym_b_q <= 1'b0;
        head_q <= '0;
      end else if (fire) begin
        cnt_q <= cnt_d;
        punct_q <= punct_d;
        letter_q <= letter_d;
        nonascii_q <= nonascii_d;
        sym_a_q <= sym_a_d;
        sym_b_q <= sym_b_d;
        head_q <= head_d;
      end
      if (fire && last_item_i) begin
        snap_valid_q <= 1'b1;
      end else if (snap_ready_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last_item_i) begin
      snap_q.kind <= ftc_pkg::file_kind_e'(file_kind_i);
      snap_q.exec_any <= exec_any_i;
      snap_q.nonascii <= nonascii_d;
      snap_q.sym_a_nz <= sym_a_d;
      snap_q.sym_b_nz <= sym_b_d;
      snap_q.head <= head_d;
      snap_cnt_q <= cnt_d;
      snap_punct_q <= punct_d;
      snap_letter_q <= letter_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o = snap_q;
  assign snap_count_o = snap_cnt_q;
  assign snap_punct_o = snap_punct_q;
  assign snap_letter_o = snap_letter_q;

endmodule

### hdl/ftc_verdict.sv
`timescale 1ns / 1ps

module ftc_verdict #(
  parameter int unsigned BlockBytes = ftc_pkg::BLOCK_BYTES_DEF,
  localparam int unsigned CntW = $clog2(BlockBytes + 1),
  localparam int unsigned PW = CntW + 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic snap_valid_i,
  output logic snap_ready_o,
  input  ftc_pkg::snap_t snap_i,
  input  logic [CntW-1:0] snap_count_i,
  input  logic [CntW-1:0] snap_punct_i,
  input  logic [CntW-1:0] snap_letter_i,
  input  logic [ftc_pkg::CfgDataW-1:0] english_pct_i,
  input  logic [ftc_pkg::CfgDataW-1:0] code_pct_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [3:0] file_class_o,
  output logic [ftc_pkg::SigIdxW-1:0] magic_entry_o,
  output logic [1:0] strip_status_o
);

  // stage 2: products for the percent tests and the signature lookup
  logic s2_valid_q, s2_ready;
  logic [PW-1:0] punct_x100_q, letter_x100_q, code_lim_q, eng_lim_q;
  ftc_pkg::file_kind_e kind_q;
  logic exec_q, nonascii_q, empty_q, hit_q, hit_d;
  logic [ftc_pkg::SigIdxW-1:0] entry_q, entry_d;
  ftc_pkg::strip_e strip_q, strip_d;

  // output register
  logic out_valid_q, out_ready_int;
  ftc_pkg::file_class_e cls_q, cls_d;
  logic [ftc_pkg::SigIdxW-1:0] out_entry_q;
  ftc_pkg::strip_e out_strip_q;

  assign out_ready_int = !out_valid_q || out_ready_i;
  assign s2_ready = !s2_valid_q || out_ready_int;
  assign snap_ready_o = s2_ready;

  // first hit wins: scan from the end so lower entries override
  always_comb begin
    hit_d = 1'b0;
    entry_d = '0;
    strip_d = ftc_pkg::STRIP_NONE;
    for (int i = ftc_pkg::SIG_COUNT - 1; i >= 0; i--) begin
      if ((snap_i.head & ftc_pkg::SIG_TABLE[i].mask) == ftc_pkg::SIG_TABLE[i].value) begin
        hit_d = 1'b1;
        entry_d = ftc_pkg::SigIdxW'(i);
        case (ftc_pkg::SIG_TABLE[i].exe)
          ftc_pkg::EXE_WORD_B: strip_d = snap_i.sym_b_nz ? ftc_pkg::STRIP_NOT_STRIPPED
                                                         : ftc_pkg::STRIP_STRIPPED;
          ftc_pkg::EXE_WORD_A: strip_d = snap_i.sym_a_nz ? ftc_pkg::STRIP_NOT_STRIPPED
                                                         : ftc_pkg::STRIP_STRIPPED;
          default: strip_d = ftc_pkg::STRIP_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= snap_valid_i;
      end
      if (out_ready_int) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && snap_valid_i) begin
      punct_x100_q <= PW'(snap_punct_i) * PW'(100);
      letter_x100_q <= PW'(snap_letter_i) * PW'(100);
      code_lim_q <= (PW'(code_pct_i) + PW'(1)) * PW'(snap_count_i);
      eng_lim_q <= (PW'(english_pct_i) + PW'(1)) * PW'(snap_count_i);
      kind_q <= snap_i.kind;
      exec_q <= snap_i.exec_any;
      nonascii_q <= snap_i.nonascii;
      empty_q <= (snap_count_i == '0);
      hit_q <= hit_d;
      entry_q <= entry_d;
      strip_q <= strip_d;
    end
  end

  always_comb begin
    case (kind_q)
      ftc_pkg::KIND_DIR: cls_d = ftc_pkg::CLS_DIR;
      ftc_pkg::KIND_CHARDEV: cls_d = ftc_pkg::CLS_CHARDEV;
      ftc_pkg::KIND_BLOCKDEV: cls_d = ftc_pkg::CLS_BLOCKDEV;
      default: begin
        if (empty_q) cls_d = ftc_pkg::CLS_EMPTY;
        else if (hit_q) cls_d = ftc_pkg::CLS_MAGIC;
        else if (exec_q) cls_d = ftc_pkg::CLS_SCRIPT;
        else if (nonascii_q) cls_d = ftc_pkg::CLS_DATA;
        else if (punct_x100_q >= code_lim_q) cls_d = ftc_pkg::CLS_C_PROG;
        else if (letter_x100_q >= eng_lim_q) cls_d = ftc_pkg::CLS_ENGLISH;
        else cls_d = ftc_pkg::CLS_ASCII;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_int && s2_valid_q) begin
      cls_q <= cls_d;
      out_entry_q <= (cls_d == ftc_pkg::CLS_MAGIC) ? entry_q : '0;
      out_strip_q <= (cls_d == ftc_pkg::CLS_MAGIC) ? strip_q : ftc_pkg::STRIP_NONE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign file_class_o = cls_q;
  assign magic_entry_o = out_entry_q;
  assign strip_status_o = out_strip_q;

endmodule

### hdl/file_type_classifier.sv
`timescale 1ns / 1ps
// The closing transaction passes through the input register, the per-file snapshot,
// the product stage and the output register, which presents its verdict.
// Throughput: one transaction per cycle while no stage stalls; each stage holds
// one item and stalls only when the stage after it is full and not draining.
// Reset: asynchronous active low; clears all counters and valid flags and loads the
// cutoff registers with their defaults (English 25, code 1).

module file_type_classifier #(
  parameter int unsigned BlockBytes = ftc_pkg::BLOCK_BYTES_DEF,
  localparam int unsigned CntW = $clog2(BlockBytes + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [ftc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ftc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic byte_present_i,
  input  logic last_item_i,
  input  logic [1:0] file_kind_i,
  input  logic exec_any_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [3:0] file_class_o,
  output logic [4:0] magic_entry_o,
  output logic [1:0] strip_status_o
);

  logic [ftc_pkg::CfgDataW-1:0] english_pct_q, code_pct_q;

  logic in_valid_q, accum_ready;
  logic [7:0] data_q;
  logic present_q, last_q, exec_q;
  logic [1:0] kind_q;

  logic snap_valid, snap_ready;
  ftc_pkg::snap_t snap;
  logic [CntW-1:0] snap_count, snap_punct, snap_letter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      english_pct_q <= ftc_pkg::ENGLISH_PCT_RESET;
      code_pct_q <= ftc_pkg::CODE_PCT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftc_pkg::CFG_ENGLISH_PCT: english_pct_q <= cfg_data_i;
        ftc_pkg::CFG_CODE_PCT: code_pct_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !in_valid_q || accum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_byte_i;
      present_q <= byte_present_i;
      last_q <= last_item_i;
      kind_q <= file_kind_i;
      exec_q <= exec_any_i;
    end
  end

  ftc_accum #(
    .BlockBytes(BlockBytes)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_valid_q),
    .item_ready_o  (accum_ready),
    .data_byte_i   (data_q),
    .byte_present_i(present_q),
    .last_item_i   (last_q),
    .file_kind_i   (kind_q),
    .exec_any_i    (exec_q),
    .snap_valid_o  (snap_valid),
    .snap_ready_i  (snap_ready),
    .snap_o        (snap),
    .snap_count_o  (snap_count),
    .snap_punct_o  (snap_punct),
    .snap_letter_o (snap_letter)
  );

  ftc_verdict #(
    .BlockBytes(BlockBytes)
  ) u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_valid_i  (snap_valid),
    .snap_ready_o  (snap_ready),
    .snap_i        (snap),
    .snap_count_i  (snap_count),
    .snap_punct_i  (snap_punct),
    .snap_letter_i (snap_letter),
    .english_pct_i (english_pct_q),
    .code_pct_i    (code_pct_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .file_class_o  (file_class_o),
    .magic_entry_o (magic_entry_o),
    .strip_status_o(strip_status_o)
  );

endmodule

### bench/ftc_checker.sv
`timescale 1ns / 1ps

module ftc_checker
  import ftc_pkg::*;
#(
  parameter int unsigned BlockBytes = BLOCK_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic byte_present_i,
  input  logic last_item_i,
  input  logic [1:0] file_kind_i,
  input  logic exec_any_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic [3:0] file_class_i,
  input  logic [4:0] magic_entry_i,
  input  logic [1:0] strip_status_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o,
  output int unsigned files_o
);

  typedef struct packed {
    file_class_e cls;
    logic [4:0] entry;
    strip_e strip;
  } verdict_t;

  typedef struct packed {
    logic [31:0] pat;
    logic [2:0] len;
    sig_exe_e exe;
  } magic_row_t;

  verdict_t verdict_q[$];

  logic [6:0] english_cut;
  logic [6:0] code_cut;
  int unsigned n_bytes;
  int unsigned n_punct;
  int unsigned n_letters;
  logic saw_high;
  logic word_a_nz;
  logic word_b_nz;
  logic [31:0] head;
  int unsigned fails;
  int unsigned files_seen;

  // signature rows, first byte of the file in the low byte
  function automatic magic_row_t magic_row(input int idx);
    magic_row_t r;
    case (idx)
      0:  r = '{{8'h00, 8'h8d, 8'h9d, 8'h1f}, 3'd3, EXE_NONE};
      1:  r = '{{8'h00, 8'h90, 8'h9d, 8'h1f}, 3'd3, EXE_NONE};
      2:  r = '{{8'h00, 8'h00, 8'hff, 8'h65}, 3'd2, EXE_NONE};
      3:  r = '{{8'h00, 8'h00, 8'hff, 8'h2c}, 3'd2, EXE_NONE};
      4:  r = '{{8'h00, 8'h00, 8'hff, 8'h65}, 3'd2, EXE_NONE};
      5:  r = '{{8'h20, 8'h75, 8'h6e, 8'h47}, 3'd4, EXE_NONE};
      6:  r = '{{8'h72, 8'h61, 8'h3c, 8'h21}, 3'd4, EXE_NONE};
      7:  r = '{{8'h00, 8'h00, 8'h02, 8'h01}, 3'd2, EXE_NONE};
      8:  r = '{{8'h00, 8'h00, 8'h86, 8'ha3}, 3'd2, EXE_NONE};
      9:  r = '{{8'h07, 8'h01, 8'h00, 8'h00}, 3'd4, EXE_NONE};
      10: r = '{{8'h00, 8'h00, 8'h01, 8'h07}, 3'd4, EXE_NONE};
      11: r = '{{8'h04, 8'h10, 8'h03, 8'h01}, 3'd4, EXE_WORD_B};
      12: r = '{{8'h04, 8'h20, 8'h03, 8'h01}, 3'd4, EXE_WORD_B};
      13: r = '{{8'h10, 8'h20, 8'h03, 8'h01}, 3'd4, EXE_WORD_B};
      14: r = '{{8'h10, 8'h10, 8'h03, 8'h01}, 3'd4, EXE_WORD_B};
      15: r = '{{8'h01, 8'h03, 8'h10, 8'h04}, 3'd4, EXE_WORD_B};
      16: r = '{{8'h0b, 8'h10, 8'h03, 8'h01}, 3'd4, EXE_WORD_B};
      17: r = '{{8'h00, 8'h00, 8'h01, 8'h0b}, 3'd4, EXE_WORD_A};
      default: r = '{{8'h01, 8'h0b, 8'h00, 8'h00}, 3'd4, EXE_WORD_A};
    endcase
    return r;
  endfunction

  function automatic void clear_file();
    n_bytes = 0;
    n_punct = 0;
    n_letters = 0;
    saw_high = 1'b0;
    word_a_nz = 1'b0;
    word_b_nz = 1'b0;
    head = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] c);
    logic [7:0] lc;
    if (n_bytes >= BlockBytes) return;
    if (n_bytes < 4) head[8*n_bytes +: 8] = c;
    if (c != 8'h00 && n_bytes >= 16 && n_bytes <= 19) word_a_nz = 1'b1;
    if (c != 8'h00 && n_bytes >= 28 && n_bytes <= 31) word_b_nz = 1'b1;
    if (c[7]) saw_high = 1'b1;
    case (c)
      ";", "{", "}", "#", "*", "<", ">", "/": n_punct++;
      default: ;
    endcase
    lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    case (lc)
      "e", "t", "a", "o", "i", "n", "s": n_letters++;
      default: ;
    endcase
    n_bytes++;
  endfunction

  // exact form of "percentage above cutoff"
  function automatic logic pct_over(input int unsigned count, input logic [6:0] cut);
    return (100 * longint'(count)) >= ((longint'(cut) + 1) * longint'(n_bytes));
  endfunction

  function automatic verdict_t classify_file(input file_kind_e kind, input logic exe);
    verdict_t v;
    magic_row_t r;
    logic [31:0] msk;
    logic hit;
    v = '{CLS_DATA, 5'd0, STRIP_NONE};
    hit = 1'b0;
    case (kind)
      KIND_DIR:      v.cls = CLS_DIR;
      KIND_CHARDEV:  v.cls = CLS_CHARDEV;
      KIND_BLOCKDEV: v.cls = CLS_BLOCKDEV;
      default: begin
        if (n_bytes == 0) begin
          v.cls = CLS_EMPTY;
        end else begin
          // bytes past the end stay zero in head, which is the padding rule
          for (int i = 0; i < 19; i++) begin
            if (!hit) begin
              r = magic_row(i);
              msk = (r.len == 3'd4) ? 32'hffff_ffff : ((32'h1 << (8 * r.len)) - 1);
              if ((head & msk) == r.pat) begin
                hit = 1'b1;
                v.entry = i[4:0];
                if (r.exe == EXE_WORD_B) v.strip = word_b_nz ? STRIP_NOT_STRIPPED : STRIP_STRIPPED;
                else if (r.exe == EXE_WORD_A) v.strip = word_a_nz ? STRIP_NOT_STRIPPED : STRIP_STRIPPED;
              end
            end
          end
          if (hit) v.cls = CLS_MAGIC;
          else if (exe) v.cls = CLS_SCRIPT;
          else if (!saw_high) begin
            if (pct_over(n_punct, code_cut)) v.cls = CLS_C_PROG;
            else if (pct_over(n_letters, english_cut)) v.cls = CLS_ENGLISH;
            else v.cls = CLS_ASCII;
          end
        end
      end
    endcase
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      english_cut = ENGLISH_PCT_RESET;
      code_cut = CODE_PCT_RESET;
      clear_file();
      verdict_q.delete();
      fails = 0;
      files_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENGLISH_PCT: english_cut = cfg_data_i;
          CFG_CODE_PCT:    code_cut = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected verdict class=%0d entry=%0d strip=%0d", $time,
                   file_class_i, magic_entry_i, strip_status_i);
        end else begin
          exp_v = verdict_q.pop_front();
          if (file_class_i !== exp_v.cls) begin
            fails++;
            $display("%0t: file_class expected %0d got %0d", $time, exp_v.cls, file_class_i);
          end
          if (magic_entry_i !== exp_v.entry) begin
            fails++;
            $display("%0t: magic_entry expected %0d got %0d", $time, exp_v.entry,
                     magic_entry_i);
          end
          if (strip_status_i !== exp_v.strip) begin
            fails++;
            $display("%0t: strip_status expected %0d got %0d", $time, exp_v.strip,
                     strip_status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (byte_present_i) absorb_byte(data_byte_i);
        if (last_item_i) begin
          verdict_q.push_back(classify_file(file_kind_e'(file_kind_i), exec_any_i));
          files_seen++;
          clear_file();
        end
      end
    end
    pending_o <= verdict_q.size();
    fail_count_o <= fails;
    files_o <= files_seen;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ftc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned SegItems = 300;
  localparam int unsigned SegFiles = 15;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] data_byte_i;
  logic byte_present_i;
  logic last_item_i;
  logic [1:0] file_kind_i;
  logic exec_any_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [3:0] file_class_o;
  logic [4:0] magic_entry_o;
  logic [1:0] strip_status_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned files_checked;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned quiet_cycles;
  int unsigned items_sent;

  logic [7:0] file_buf [0:1199];
  int unsigned file_len;

  file_type_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_item_i   (last_item_i),
    .file_kind_i   (file_kind_i),
    .exec_any_i    (exec_any_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .file_class_o  (file_class_o),
    .magic_entry_o (magic_entry_o),
    .strip_status_o(strip_status_o)
  );

  ftc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_item_i   (last_item_i),
    .file_kind_i   (file_kind_i),
    .exec_any_i    (exec_any_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .file_class_i  (file_class_o),
    .magic_entry_i (magic_entry_o),
    .strip_status_i(strip_status_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .files_o       (files_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic last,
                           input logic [1:0] kind, input logic exe);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    data_byte_i = b;
    byte_present_i = present;
    last_item_i = last;
    file_kind_i = kind;
    exec_any_i = exe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (present || last) items_sent++;
  endtask

  // hold off until every verdict is back and the pipeline is empty
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic fill_file(output file_kind_e kind, output logic exe, output logic bare_close);
    int unsigned style;
    int unsigned e;
    int unsigned p_punct;
    int unsigned p_letter;
    int unsigned r;
    string puncts;
    string letters;
    puncts = ";{}#*<>/";
    letters = "etaoinsETAOINS";
    style = $urandom_range(9, 0);
    p_punct = $urandom_range(30, 0);
    p_letter = $urandom_range(80, 0);
    if (style <= 2 && $urandom_range(3, 0) == 0) file_len = $urandom_range(4, 1);
    else if (style <= 2) file_len = $urandom_range(40, 20);
    else file_len = $urandom_range(40, 0);
    if ($urandom_range(39, 0) == 0) file_len = $urandom_range(1100, 1000);
    for (int i = 0; i < 1200; i++) begin
      if (style <= 6 && style >= 3) begin
        r = $urandom_range(99, 0);
        if (r < p_punct) file_buf[i] = puncts[$urandom_range(7, 0)];
        else if (r < p_punct + p_letter) file_buf[i] = letters[$urandom_range(13, 0)];
        else file_buf[i] = 8'($urandom_range(127, 0));
      end else if (style == 9) begin
        file_buf[i] = 8'($urandom_range(127, 0));
      end else begin
        file_buf[i] = 8'($urandom_range(255, 0));
      end
    end
    if (style >= 3 && style <= 6 && $urandom_range(7, 0) == 0)
      file_buf[$urandom_range(39, 0)] = 8'($urandom_range(255, 128));
    if (style <= 2) begin
      e = $urandom_range(SIG_COUNT - 1, 0);
      for (int k = 0; k < 4; k++) begin
        if (SIG_TABLE[e].mask[8*k +: 8] != 8'h00) file_buf[k] = SIG_TABLE[e].value[8*k +: 8];
      end
      // near misses
      if ($urandom_range(5, 0) == 0) file_buf[$urandom_range(3, 0)] ^= 8'h01 << $urandom_range(7, 0);
    end
    if (style <= 2 || style >= 7) begin
      // symbol words: sometimes all zero, sometimes a single nonzero byte, else left random
      if ($urandom_range(1, 0) == 1) begin
        for (int k = 16; k < 20; k++) file_buf[k] = 8'h00;
        if ($urandom_range(1, 0) == 1) file_buf[$urandom_range(19, 16)] = 8'($urandom_range(255, 1));
      end
      if ($urandom_range(1, 0) == 1) begin
        for (int k = 28; k < 32; k++) file_buf[k] = 8'h00;
        if ($urandom_range(1, 0) == 1) file_buf[$urandom_range(31, 28)] = 8'($urandom_range(255, 1));
      end
    end
    kind = ($urandom_range(7, 0) == 0) ? file_kind_e'($urandom_range(3, 1)) : KIND_REGULAR;
    exe = ($urandom_range(6, 0) == 0);
    bare_close = ($urandom_range(4, 0) == 0);
  endtask

  // kind and exec bits on non-closing transactions are noise
  task automatic send_file(input file_kind_e kind, input logic exe, input logic bare_close);
    logic closing;
    for (int i = 0; i < file_len; i++) begin
      if ($urandom_range(9, 0) == 0)
        send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 2'($urandom_range(3, 0)),
                  1'($urandom_range(1, 0)));
      closing = (i == file_len - 1) && !bare_close;
      send_item(file_buf[i], 1'b1, closing, closing ? 2'(kind) : 2'($urandom_range(3, 0)),
                closing ? exe : 1'($urandom_range(1, 0)));
    end
    if (bare_close || file_len == 0)
      send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, kind, exe);
  endtask

  initial begin
    logic [6:0] eng_cut [6];
    logic [6:0] code_cut [6];
    file_kind_e kind;
    logic exe;
    logic bare_close;
    int unsigned seg_start;
    int unsigned seg_files;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ENGLISH_PCT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    byte_present_i = 1'b0;
    last_item_i = 1'b0;
    file_kind_i = KIND_REGULAR;
    exec_any_i = 1'b0;
    items_sent = 0;
    tx_idle_pct = 18;
    rx_idle_pct = 58;
    eng_cut = '{7'd25, 7'd0, 7'd100, 7'd127, 7'd60, 7'd0};
    code_cut = '{7'd1, 7'd0, 7'd100, 7'd127, 7'd5, 7'd0};
    eng_cut[5] = 7'($urandom_range(127, 0));
    code_cut[5] = 7'($urandom_range(127, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: special kinds, empty file, short signatures, each text verdict
    send_item(8'h00, 1'b0, 1'b1, KIND_DIR, 1'b1);
    send_item(8'hff, 1'b0, 1'b1, KIND_CHARDEV, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1, KIND_BLOCKDEV, 1'b1);
    send_item(8'h41, 1'b0, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h3b, 1'b0, 1'b0, KIND_DIR, 1'b1);
    send_item(8'h01, 1'b1, 1'b0, KIND_BLOCKDEV, 1'b1);
    send_item(8'h02, 1'b1, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h0b, 1'b1, 1'b0, KIND_REGULAR, 1'b0);
    send_item(8'h01, 1'b1, 1'b1, KIND_REGULAR, 1'b1);
    send_item(8'h65, 1'b1, 1'b0, KIND_REGULAR, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h80, 1'b1, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h23, 1'b1, 1'b0, KIND_REGULAR, 1'b0);
    send_item(8'h21, 1'b1, 1'b1, KIND_REGULAR, 1'b1);
    send_item(8'h7b, 1'b1, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h45, 1'b1, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1, KIND_REGULAR, 1'b0);
    send_item(8'h61, 1'b1, 1'b0, KIND_REGULAR, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, KIND_REGULAR, 1'b0);

    for (int s = 0; s < 6; s++) begin
      tx_idle_pct = (s < 2) ? 18 : (s < 4) ? 58 : 0;
      rx_idle_pct = (s < 2) ? 58 : (s < 4) ? 18 : 0;
      drain();
      write_cfg(CFG_ENGLISH_PCT, eng_cut[s]);
      write_cfg(CFG_CODE_PCT, code_cut[s]);
      seg_start = items_sent;
      seg_files = 0;
      while (items_sent - seg_start < SegItems || seg_files < SegFiles) begin
        fill_file(kind, exe, bare_close);
        send_file(kind, exe, bare_close);
        seg_files++;
      end
    end

    drain();
    $display("summary: %0d byte/closing transactions, %0d files classified", items_sent,
             files_checked);
    $display("summary: 6 cutoff settings incl. 0, 100 and 127; %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
